>>> rtl/battery_voltage_gauge_defines.svh
// assertion macros for the battery voltage gauge
// used by the top level only; expects clk and rst_n in scope
`ifndef BATTERY_VOLTAGE_GAUGE_DEFINES_SVH
`define BATTERY_VOLTAGE_GAUGE_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define BVG_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while in reset
`define BVG_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/bvg_pkg.sv
// shared types and constants of the battery voltage gauge
// no dependencies; used by bvg_alu and battery_voltage_gauge
package bvg_pkg;

    // default parameter values
    localparam int TablePointsDef = 22;
    localparam int MaxSamplesDef  = 255;

    // widths
    localparam int ArW        = 56;
    localparam int IdxW       = 5;
    localparam int TableSlots = 32;
    localparam int VoltW      = 14;

    // arithmetic constants (units of 1e-7 mV for the correction)
    localparam int Scale      = 10000000;
    localparam int PolyLin    = 10096000;
    localparam int PolySq     = 28;
    localparam int PolyOff    = 510000000;

    // voltage thresholds in mV
    localparam logic [VoltW-1:0] VoltFloorMv = 14'd1000;
    localparam logic [VoltW-1:0] VoltMaxMv   = 14'd16383;
    localparam logic [VoltW-1:0] LowWarnMv   = 14'd2800;
    localparam logic [VoltW-1:0] Bar6Mv      = 14'd3820;
    localparam logic [VoltW-1:0] Bar5Mv      = 14'd3720;
    localparam logic [VoltW-1:0] Bar4Mv      = 14'd3610;
    localparam logic [VoltW-1:0] Bar3Mv      = 14'd3460;
    localparam logic [VoltW-1:0] Bar2Mv      = 14'd3330;
    localparam logic [VoltW-1:0] Bar1Mv      = 14'd3200;

    // li-ion discharge curve, 5 % per segment, unused slots repeat the top point
    localparam logic [VoltW-1:0] ChargeTable [TableSlots] = '{
        14'd2600, 14'd3100, 14'd3200, 14'd3260, 14'd3290, 14'd3330, 14'd3370, 14'd3410,
        14'd3460, 14'd3510, 14'd3560, 14'd3610, 14'd3650, 14'd3690, 14'd3720, 14'd3750,
        14'd3780, 14'd3820, 14'd3880, 14'd3950, 14'd4030, 14'd4250, 14'd4250, 14'd4250,
        14'd4250, 14'd4250, 14'd4250, 14'd4250, 14'd4250, 14'd4250, 14'd4250, 14'd4250
    };

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_SAMPLE_COUNT,
        CFG_DIVIDER_TOP,
        CFG_DIVIDER_BOTTOM,
        CFG_OFFSET
    } cfg_reg_t;

    // sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIV_AVG,
        ST_SQUARE,
        ST_POLY,
        ST_MUL,
        ST_OFFSET,
        ST_DIV_V,
        ST_VOLT,
        ST_WALK,
        ST_PDIV,
        ST_FINISH
    } state_t;

    // shared adder control and status
    typedef struct packed {
        logic sub;
    } alu_ctrl_t;

    typedef struct packed {
        logic carry;
        logic sign;
    } alu_stat_t;

endpackage

>>> rtl/bvg_alu.sv
// shared wide add/subtract unit of the battery voltage gauge
// depends on bvg_pkg; carry out doubles as the unsigned a >= b compare
module bvg_alu (
    input  logic [bvg_pkg::ArW-1:0] a,
    input  logic [bvg_pkg::ArW-1:0] b,
    input  bvg_pkg::alu_ctrl_t      ctrl,
    output logic [bvg_pkg::ArW-1:0] sum,
    output bvg_pkg::alu_stat_t      stat
);

    localparam int ArW = bvg_pkg::ArW;

    logic [ArW:0] full;

    // a + b, or a - b as a + ~b + 1
    assign full = {1'b0, a} + {1'b0, b ^ {ArW{ctrl.sub}}} + (ArW + 1)'(ctrl.sub);

    assign sum        = full[ArW-1:0];
    assign stat.carry = full[ArW];
    assign stat.sign  = full[ArW-1];

endmodule

>>> rtl/battery_voltage_gauge.sv
// battery voltage gauge: averages samples and derives voltage, charge and flags
// depends on bvg_pkg, bvg_alu and battery_voltage_gauge_defines.svh
//
// Usage
//   Input: pulse start with sample_mv while busy is low; the item is taken at
//   that edge. Samples are summed until sample_count of them have arrived.
//   Samples that do not close a measurement leave busy low.
//   The closing sample raises busy while the sequencer runs one 56-bit adder
//   through a 12-step average division, a 17-step serial multiply by the
//   divider sum, a 16-step voltage division, a table walk of up to
//   TABLE_POINTS steps and a 3-step interpolation divide.
//   Negative corrected voltages skip the voltage division.
//   Output: result_valid is high for one cycle, the cycle in which busy falls,
//   with battery_mv, charge_percent, charging, bar_squares and low_warning.
//   The receiver has no back-pressure; it takes each result as it appears.
//   Configuration: cfg_valid with cfg_index and cfg_data, always ready, to be
//   written only while the block is idle.
//   Reset: registers return to their defaults (100 samples, 50/100 ohm
//   divider, no offset), the running sum and the voltage history clear.
`include "battery_voltage_gauge_defines.svh"

module battery_voltage_gauge #(
    parameter int TABLE_POINTS = bvg_pkg::TablePointsDef,
    parameter int MAX_SAMPLES  = bvg_pkg::MaxSamplesDef
) (
    input  logic        clk,
    input  logic        rst_n,
    // sample channel
    input  logic        start,
    output logic        busy,
    input  logic [11:0] sample_mv,
    // configuration channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    // result channel
    output logic        result_valid,
    output logic [13:0] battery_mv,
    output logic [6:0]  charge_percent,
    output logic        charging,
    output logic [2:0]  bar_squares,
    output logic        low_warning
);

    localparam int ArW   = bvg_pkg::ArW;
    localparam int IdxW  = bvg_pkg::IdxW;
    localparam int VoltW = bvg_pkg::VoltW;
    localparam logic [IdxW-1:0] LastIdx = IdxW'(TABLE_POINTS - 1);

    // control state
    bvg_pkg::state_t   state_reg, state_next;
    logic [7:0]        sample_count_reg, sample_count_next;
    logic [15:0]       top_ohms_reg, top_ohms_next;
    logic [15:0]       bot_ohms_reg, bot_ohms_next;
    logic [10:0]       offset_reg, offset_next;
    logic [19:0]       sample_sum_reg, sample_sum_next;
    logic [7:0]        samples_taken_reg, samples_taken_next;
    logic [VoltW-1:0]  hist_reg [4];
    logic [VoltW-1:0]  hist_next [4];
    logic [4:0]        step_reg, step_next;
    logic              valid_reg, valid_next;

    // datapath
    logic [ArW-1:0]    rem_reg, rem_next;
    logic [ArW-1:0]    dsh_reg, dsh_next;
    logic [15:0]       q_reg, q_next;
    logic [16:0]       mplier_reg, mplier_next;
    logic [23:0]       sq_reg, sq_next;
    logic [39:0]       bk_reg, bk_next;
    logic              neg_reg, neg_next;
    logic [VoltW-1:0]  v_reg, v_next;
    logic [IdxW-1:0]   i_reg, i_next;
    logic [6:0]        pct_reg, pct_next;
    logic [VoltW-1:0]  mv_out_reg, mv_out_next;
    logic [6:0]        pct_out_reg, pct_out_next;
    logic              chg_out_reg, chg_out_next;
    logic [2:0]        bar_out_reg, bar_out_next;
    logic              low_out_reg, low_out_next;

    // shared adder
    logic [ArW-1:0]      alu_a, alu_b, alu_sum;
    bvg_pkg::alu_ctrl_t  alu_ctrl;
    bvg_pkg::alu_stat_t  alu_stat;

    // item bookkeeping
    logic [7:0]        cnt_eff;
    logic [7:0]        taken_inc;
    logic [19:0]       sum_inc;
    logic              accept;
    logic              final_item;
    logic [15:0]       bot_eff;
    logic              walk_more;
    logic [IdxW-1:0]   i_inc;

    // icon fill level from fixed thresholds
    function automatic logic [2:0] bar_level(input logic [VoltW-1:0] v);
        logic [2:0] lvl;
        priority if (v >= bvg_pkg::Bar6Mv) lvl = 3'd6;
        else if (v >= bvg_pkg::Bar5Mv)     lvl = 3'd5;
        else if (v >= bvg_pkg::Bar4Mv)     lvl = 3'd4;
        else if (v >= bvg_pkg::Bar3Mv)     lvl = 3'd3;
        else if (v >= bvg_pkg::Bar2Mv)     lvl = 3'd2;
        else if (v >= bvg_pkg::Bar1Mv)     lvl = 3'd1;
        else                               lvl = 3'd0;
        return lvl;
    endfunction

    // effective sample count: zero means one, capped at the maximum
    always_comb
    begin
        cnt_eff = (sample_count_reg == 8'd0) ? 8'd1 : sample_count_reg;
        if (int'(cnt_eff) > MAX_SAMPLES)
        begin
            cnt_eff = 8'(MAX_SAMPLES);
        end
    end

    assign bot_eff    = (bot_ohms_reg == 16'd0) ? 16'd1 : bot_ohms_reg;
    assign busy       = (state_reg != bvg_pkg::ST_IDLE);
    assign cfg_ready  = 1'b1;
    assign accept     = start && !busy;
    assign taken_inc  = samples_taken_reg + 8'd1;
    assign sum_inc    = sample_sum_reg + 20'(sample_mv);
    assign final_item = (taken_inc >= cnt_eff);
    assign i_inc      = i_reg + IdxW'(1);
    assign walk_more  = (i_reg < LastIdx) && (v_reg >= bvg_pkg::ChargeTable[i_inc]);

    // adder operand selection
    always_comb
    begin
        alu_ctrl.sub = (state_reg == bvg_pkg::ST_DIV_AVG) || (state_reg == bvg_pkg::ST_DIV_V)
                    || (state_reg == bvg_pkg::ST_PDIV);
        if (state_reg == bvg_pkg::ST_OFFSET)
        begin
            alu_a = {rem_reg[ArW-2:0], 1'b0};
            alu_b = ArW'(bk_reg);
        end
        else
        begin
            alu_a = rem_reg;
            alu_b = dsh_reg;
        end
    end

    bvg_alu u_alu (
        .a    (alu_a),
        .b    (alu_b),
        .ctrl (alu_ctrl),
        .sum  (alu_sum),
        .stat (alu_stat)
    );

    // sequencer next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            bvg_pkg::ST_IDLE:
            begin
                if (accept && final_item) state_next = bvg_pkg::ST_DIV_AVG;
            end
            bvg_pkg::ST_DIV_AVG:
            begin
                if (step_reg == 5'd1) state_next = bvg_pkg::ST_SQUARE;
            end
            bvg_pkg::ST_SQUARE: state_next = bvg_pkg::ST_POLY;
            bvg_pkg::ST_POLY:   state_next = bvg_pkg::ST_MUL;
            bvg_pkg::ST_MUL:
            begin
                if (step_reg == 5'd1) state_next = bvg_pkg::ST_OFFSET;
            end
            bvg_pkg::ST_OFFSET:
            begin
                state_next = alu_stat.sign ? bvg_pkg::ST_VOLT : bvg_pkg::ST_DIV_V;
            end
            bvg_pkg::ST_DIV_V:
            begin
                if (step_reg == 5'd1) state_next = bvg_pkg::ST_VOLT;
            end
            bvg_pkg::ST_VOLT: state_next = bvg_pkg::ST_WALK;
            bvg_pkg::ST_WALK:
            begin
                if (!walk_more)
                begin
                    if ((i_reg >= LastIdx) || (v_reg < bvg_pkg::ChargeTable[i_reg]))
                        state_next = bvg_pkg::ST_FINISH;
                    else
                        state_next = bvg_pkg::ST_PDIV;
                end
            end
            bvg_pkg::ST_PDIV:
            begin
                if (step_reg == 5'd1) state_next = bvg_pkg::ST_FINISH;
            end
            bvg_pkg::ST_FINISH: state_next = bvg_pkg::ST_IDLE;
            default:            state_next = bvg_pkg::ST_IDLE;
        endcase
    end

    // datapath and bookkeeping next values
    always_comb
    begin
        logic [35:0]         lin;
        logic [29:0]         quad;
        logic signed [16:0]  vs;
        logic [VoltW-1:0]    lo, hi, diff, span;
        logic [2:0]          qf;
        logic [7:0]          pct_full;

        lin      = 36'(q_reg[11:0]) * 36'(bvg_pkg::PolyLin);
        quad     = 30'(sq_reg) * 30'(bvg_pkg::PolySq);
        vs       = $signed({2'b00, q_reg[14:0]}) + $signed({{6{offset_reg[10]}}, offset_reg});
        lo       = bvg_pkg::ChargeTable[i_reg];
        hi       = bvg_pkg::ChargeTable[i_inc];
        diff     = v_reg - lo;
        span     = hi - lo;
        qf       = {q_reg[1:0], alu_stat.carry};
        pct_full = 8'({i_reg, 2'b00}) + 8'(i_reg) + 8'(qf);

        sample_count_next  = sample_count_reg;
        top_ohms_next      = top_ohms_reg;
        bot_ohms_next      = bot_ohms_reg;
        offset_next        = offset_reg;
        sample_sum_next    = sample_sum_reg;
        samples_taken_next = samples_taken_reg;
        hist_next          = hist_reg;
        step_next          = step_reg;
        valid_next         = 1'b0;
        rem_next           = rem_reg;
        dsh_next           = dsh_reg;
        q_next             = q_reg;
        mplier_next        = mplier_reg;
        sq_next            = sq_reg;
        bk_next            = bk_reg;
        neg_next           = neg_reg;
        v_next             = v_reg;
        i_next             = i_reg;
        pct_next           = pct_reg;
        mv_out_next        = mv_out_reg;
        pct_out_next       = pct_out_reg;
        chg_out_next       = chg_out_reg;
        bar_out_next       = bar_out_reg;
        low_out_next       = low_out_reg;

        // register writes
        if (cfg_valid)
        begin
            unique case (bvg_pkg::cfg_reg_t'(cfg_index))
                bvg_pkg::CFG_SAMPLE_COUNT:   sample_count_next = cfg_data[7:0];
                bvg_pkg::CFG_DIVIDER_TOP:    top_ohms_next     = cfg_data;
                bvg_pkg::CFG_DIVIDER_BOTTOM: bot_ohms_next     = cfg_data;
                bvg_pkg::CFG_OFFSET:         offset_next       = cfg_data[10:0];
            endcase
        end

        unique case (state_reg)
            bvg_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    if (final_item)
                    begin
                        // rounded average: (2*sum + n) / (2*n)
                        sample_sum_next    = '0;
                        samples_taken_next = '0;
                        rem_next  = ArW'({sum_inc, 1'b0}) + ArW'(taken_inc);
                        dsh_next  = ArW'({taken_inc, 1'b0}) << 11;
                        q_next    = '0;
                        step_next = 5'd12;
                    end
                    else
                    begin
                        sample_sum_next    = sum_inc;
                        samples_taken_next = taken_inc;
                    end
                end
            end
            bvg_pkg::ST_DIV_AVG, bvg_pkg::ST_DIV_V:
            begin
                // one restoring division step
                if (alu_stat.carry) rem_next = alu_sum;
                q_next    = {q_reg[14:0], alu_stat.carry};
                dsh_next  = dsh_reg >> 1;
                step_next = step_reg - 5'd1;
            end
            bvg_pkg::ST_SQUARE:
            begin
                sq_next     = 24'(q_reg[11:0]) * 24'(q_reg[11:0]);
                bk_next     = 40'(bot_eff) * 40'(bvg_pkg::Scale);
                mplier_next = 17'(top_ohms_reg) + 17'(bot_eff);
            end
            bvg_pkg::ST_POLY:
            begin
                // quadratic correction, may go negative
                rem_next  = '0;
                dsh_next  = ArW'(lin) + ArW'(quad) - ArW'(bvg_pkg::PolyOff);
                step_next = 5'd17;
            end
            bvg_pkg::ST_MUL:
            begin
                // serial multiply by the divider sum, lsb first
                if (mplier_reg[0]) rem_next = alu_sum;
                dsh_next    = dsh_reg << 1;
                mplier_next = mplier_reg >> 1;
                step_next   = step_reg - 5'd1;
            end
            bvg_pkg::ST_OFFSET:
            begin
                // numerator 2*P*(top+bot) + bot*1e7, divisor 2*bot*1e7
                rem_next  = alu_sum;
                neg_next  = alu_stat.sign;
                dsh_next  = ArW'(bk_reg) << 16;
                q_next    = '0;
                step_next = 5'd16;
            end
            bvg_pkg::ST_VOLT:
            begin
                // offset, floor to zero and saturate
                if (neg_reg)
                    v_next = '0;
                else if (q_reg[15])
                    v_next = bvg_pkg::VoltMaxMv;
                else if (vs < $signed(17'(bvg_pkg::VoltFloorMv)))
                    v_next = '0;
                else if (vs > $signed(17'(bvg_pkg::VoltMaxMv)))
                    v_next = bvg_pkg::VoltMaxMv;
                else
                    v_next = vs[VoltW-1:0];
                i_next = '0;
            end
            bvg_pkg::ST_WALK:
            begin
                if (walk_more)
                    i_next = i_inc;
                else if (i_reg >= LastIdx)
                    pct_next = 7'd100;
                else if (v_reg < lo)
                    pct_next = 7'd0;
                else
                begin
                    // rounded fraction of the segment: (10*dv + d) / (2*d)
                    rem_next  = ArW'({diff, 3'b000}) + ArW'({diff, 1'b0}) + ArW'(span);
                    dsh_next  = ArW'(span) << 3;
                    q_next    = '0;
                    step_next = 5'd3;
                end
            end
            bvg_pkg::ST_PDIV:
            begin
                if (alu_stat.carry) rem_next = alu_sum;
                q_next    = {q_reg[14:0], alu_stat.carry};
                dsh_next  = dsh_reg >> 1;
                step_next = step_reg - 5'd1;
                pct_next  = (pct_full > 8'd100) ? 7'd100 : pct_full[6:0];
            end
            bvg_pkg::ST_FINISH:
            begin
                mv_out_next  = v_reg;
                pct_out_next = pct_reg;
                chg_out_next = (v_reg > hist_reg[0]) && (hist_reg[0] > hist_reg[1])
                            && (hist_reg[1] > hist_reg[2]) && (hist_reg[2] > hist_reg[3]);
                bar_out_next = bar_level(v_reg);
                low_out_next = (v_reg < bvg_pkg::LowWarnMv);
                hist_next[3] = hist_reg[2];
                hist_next[2] = hist_reg[1];
                hist_next[1] = hist_reg[0];
                hist_next[0] = v_reg;
                valid_next   = 1'b1;
            end
            default:
            begin
                step_next = step_reg;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= bvg_pkg::ST_IDLE;
            sample_count_reg  <= 8'd100;
            top_ohms_reg      <= 16'd50;
            bot_ohms_reg      <= 16'd100;
            offset_reg        <= '0;
            sample_sum_reg    <= '0;
            samples_taken_reg <= '0;
            hist_reg          <= '{default: '0};
            step_reg          <= '0;
            valid_reg         <= 1'b0;
        end
        else
        begin
            state_reg         <= state_next;
            sample_count_reg  <= sample_count_next;
            top_ohms_reg      <= top_ohms_next;
            bot_ohms_reg      <= bot_ohms_next;
            offset_reg        <= offset_next;
            sample_sum_reg    <= sample_sum_next;
            samples_taken_reg <= samples_taken_next;
            hist_reg          <= hist_next;
            step_reg          <= step_next;
            valid_reg         <= valid_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        rem_reg     <= rem_next;
        dsh_reg     <= dsh_next;
        q_reg       <= q_next;
        mplier_reg  <= mplier_next;
        sq_reg      <= sq_next;
        bk_reg      <= bk_next;
        neg_reg     <= neg_next;
        v_reg       <= v_next;
        i_reg       <= i_next;
        pct_reg     <= pct_next;
        mv_out_reg  <= mv_out_next;
        pct_out_reg <= pct_out_next;
        chg_out_reg <= chg_out_next;
        bar_out_reg <= bar_out_next;
        low_out_reg <= low_out_next;
    end

    // result ports
    assign result_valid   = valid_reg;
    assign battery_mv     = mv_out_reg;
    assign charge_percent = pct_out_reg;
    assign charging       = chg_out_reg;
    assign bar_squares    = bar_out_reg;
    assign low_warning    = low_out_reg;

    // checks
    `BVG_ASSERT_NEXT(a_strobe_single, result_valid, !result_valid, "result strobe held over")
    `BVG_ASSERT_NEXT(a_final_busy, accept && final_item, busy, "closing item left block idle")
    `BVG_ASSERT_SAME(a_ranges, result_valid, (charge_percent <= 7'd100) && (bar_squares <= 3'd6), "result field out of range")
    `BVG_ASSERT_SAME(a_zero_volt, result_valid && (battery_mv == 14'd0), low_warning && (charge_percent == 7'd0), "zero voltage gave charge")

endmodule

>>> sim/testbench.sv
`timescale 1ns / 1ps
// testbench for battery_voltage_gauge: directed and random converter samples with
// register changes between phases, readings checked against an in-bench predictor
// depends on bvg_pkg and the battery_voltage_gauge rtl; reads no files

module testbench;

    localparam int SETTLE_CYCLES   = 100;
    localparam int WATCHDOG_LIMIT  = 5000;
    localparam int MAX_REPORTS     = 10;
    localparam int RANDOM_PHASES   = 12;
    localparam int ITEMS_PER_PHASE = 27;
    localparam int LONG_COUNT      = 255;
    localparam int CURVE_LAST      = 21;
    localparam longint SCALE       = 64'sd10000000;

    // li-ion discharge curve in mV, 5 % per segment
    localparam int CURVE_MV [22] = '{
        2600, 3100, 3200, 3260, 3290, 3330, 3370, 3410, 3460, 3510, 3560,
        3610, 3650, 3690, 3720, 3750, 3780, 3820, 3880, 3950, 4030, 4250
    };

    // one sample per measurement, rising through the curve, then a repeat, a drop and full scale
    localparam logic [11:0] DIRECTED_MV [14] = '{
        12'd0, 12'd51, 12'd52, 12'd700, 12'd712, 12'd1760, 12'd2000,
        12'd2200, 12'd2400, 12'd2600, 12'd2800, 12'd2800, 12'd2100, 12'd4095
    };

    typedef struct packed {
        logic [13:0] mv;
        logic [6:0]  pct;
        logic        chg;
        logic [2:0]  bars;
        logic        low;
    } gauge_reading_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [11:0] sample_mv = '0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [15:0] cfg_data = '0;
    logic        result_valid;
    logic [13:0] battery_mv;
    logic [6:0]  charge_percent;
    logic        charging;
    logic [2:0]  bar_squares;
    logic        low_warning;

    // predictor copy of the registers and the running state
    logic [7:0]         count_reg = 8'd100;
    logic [15:0]        top_reg = 16'd50;
    logic [15:0]        bot_reg = 16'd100;
    logic signed [10:0] offset_reg = '0;
    int unsigned        acc_sum = 0;
    int unsigned        acc_taken = 0;
    int                 volt_hist [4] = '{0, 0, 0, 0};

    logic [11:0]    sample_queue [$];
    gauge_reading_t pending_readings [$];

    int sender_idle_pct = 33;
    int samples_queued = 0;
    int samples_accepted = 0;
    int readings_checked = 0;
    int rising_seen = 0;
    int reg_writes = 0;
    int mismatches = 0;
    int quiet_cycles = 0;

    battery_voltage_gauge u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .sample_mv      (sample_mv),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .result_valid   (result_valid),
        .battery_mv     (battery_mv),
        .charge_percent (charge_percent),
        .charging       (charging),
        .bar_squares    (bar_squares),
        .low_warning    (low_warning)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // accumulate one sample; returns 1 with the reading when a measurement closes
    function automatic bit measure_battery(input logic [11:0] mv, output gauge_reading_t rd);
        int unsigned need;
        longint      avg;
        longint      poly;
        longint      top;
        longint      bot;
        longint      num;
        longint      den;
        longint      volt;
        int          v;
        int          seg;
        int          span;
        int          pct;
        bit          rising;
        need = (count_reg == 8'd0) ? 1 : count_reg;
        acc_sum += mv;
        acc_taken++;
        rd = '0;
        if (acc_taken < need)
            return 1'b0;

        // rounded average, quadratic fix, divider scaling and offset
        avg = (2 * longint'(acc_sum) + acc_taken) / (2 * longint'(acc_taken));
        acc_sum = 0;
        acc_taken = 0;
        poly = SCALE * avg + 28 * avg * avg + 96000 * avg - 64'sd510000000;
        top = longint'(top_reg);
        bot = (bot_reg == 16'd0) ? 64'sd1 : longint'(bot_reg);
        num = 2 * poly * (top + bot) + bot * SCALE;
        den = 2 * bot * SCALE;
        volt = num / den;
        if ((num % den) != 0 && num < 0)
            volt = volt - 1;
        volt = volt + longint'(offset_reg);
        if (volt < 1000)
            volt = 0;
        if (volt > 16383)
            volt = 16383;
        v = int'(volt);

        // strictly rising over the last five measurements
        rising = v > volt_hist[0] && volt_hist[0] > volt_hist[1] &&
                 volt_hist[1] > volt_hist[2] && volt_hist[2] > volt_hist[3];
        volt_hist[3] = volt_hist[2];
        volt_hist[2] = volt_hist[1];
        volt_hist[1] = volt_hist[0];
        volt_hist[0] = v;

        // interpolate over the curve
        seg = 0;
        while (seg < CURVE_LAST && v >= CURVE_MV[seg + 1])
            seg++;
        if (seg >= CURVE_LAST)
            pct = 100;
        else if (v < CURVE_MV[seg])
            pct = 0;
        else
        begin
            span = CURVE_MV[seg + 1] - CURVE_MV[seg];
            pct = 5 * seg + (10 * (v - CURVE_MV[seg]) + span) / (2 * span);
            if (pct > 100)
                pct = 100;
        end

        rd.mv = v[13:0];
        rd.pct = pct[6:0];
        rd.chg = rising;
        if (v >= 3820)
            rd.bars = 3'd6;
        else if (v >= 3720)
            rd.bars = 3'd5;
        else if (v >= 3610)
            rd.bars = 3'd4;
        else if (v >= 3460)
            rd.bars = 3'd3;
        else if (v >= 3330)
            rd.bars = 3'd2;
        else if (v >= 3200)
            rd.bars = 3'd1;
        else
            rd.bars = 3'd0;
        rd.low = (v < 2800);
        return 1'b1;
    endfunction

    task automatic queue_sample(input logic [11:0] mv);
        sample_queue.push_back(mv);
        samples_queued++;
    endtask

    // one register write on the configuration channel
    task automatic write_reg(input bvg_pkg::cfg_reg_t idx, input logic [15:0] data);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // wait until every sample is taken and every reading has come out
    task automatic drain_block();
        while (samples_accepted != samples_queued || pending_readings.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // sample driver, fed from the item queue with random gaps
    always @(posedge clk or negedge rst_n)
    begin : sample_driver
        if (!rst_n)
        begin
            start <= 1'b0;
            sample_mv <= '0;
        end
        else if (!(start && busy))
        begin
            if (sample_queue.size() != 0 && $urandom_range(99) >= sender_idle_pct)
            begin
                start <= 1'b1;
                sample_mv <= sample_queue.pop_front();
            end
            else
            begin
                start <= 1'b0;
            end
        end
    end

    // monitor: predicts on accepted items, checks readings, tracks register writes
    always @(posedge clk)
    begin : reading_monitor
        gauge_reading_t want;
        gauge_reading_t got;
        if (rst_n)
        begin
            // check a reading against the oldest expectation
            if (result_valid)
            begin
                got.mv = battery_mv;
                got.pct = charge_percent;
                got.chg = charging;
                got.bars = bar_squares;
                got.low = low_warning;
                if (pending_readings.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("%0t: unexpected reading mv=%0d pct=%0d chg=%0d bars=%0d low=%0d",
                                 $realtime, got.mv, got.pct, got.chg, got.bars, got.low);
                end
                else
                begin
                    want = pending_readings.pop_front();
                    readings_checked++;
                    if (want.chg)
                        rising_seen++;
                    if (got.mv !== want.mv || got.pct !== want.pct || got.chg !== want.chg ||
                        got.bars !== want.bars || got.low !== want.low)
                    begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS)
                            $display("%0t: reading mismatch exp mv=%0d pct=%0d chg=%0d bars=%0d low=%0d, got mv=%0d pct=%0d chg=%0d bars=%0d low=%0d",
                                     $realtime, want.mv, want.pct, want.chg, want.bars, want.low,
                                     got.mv, got.pct, got.chg, got.bars, got.low);
                    end
                end
            end

            // accepted sample
            if (start && !busy)
            begin
                samples_accepted++;
                if (measure_battery(sample_mv, want))
                    pending_readings.push_back(want);
            end

            // accepted register write
            if (cfg_valid && cfg_ready)
            begin
                reg_writes++;
                case (bvg_pkg::cfg_reg_t'(cfg_index))
                    bvg_pkg::CFG_SAMPLE_COUNT:   count_reg = cfg_data[7:0];
                    bvg_pkg::CFG_DIVIDER_TOP:    top_reg = cfg_data;
                    bvg_pkg::CFG_DIVIDER_BOTTOM: bot_reg = cfg_data;
                    bvg_pkg::CFG_OFFSET:         offset_reg = cfg_data[10:0];
                    default:                     ;
                endcase
            end

            // watchdog on cycles without any handshake
            if (result_valid || (start && !busy) || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: no handshake for %0d cycles", $realtime, WATCHDOG_LIMIT);
                $display("battery_voltage_gauge test failed");
                $finish;
            end
        end
    end

    // stimulus sequence
    initial
    begin : stimulus
        int          p;
        int          k;
        int          pick;
        int          level;
        bit          ramp;
        logic [7:0]  count_val;
        logic [7:0]  count_hi;
        logic [15:0] top_val;
        logic [15:0] bot_val;
        logic [10:0] off_val;
        logic [4:0]  off_hi;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // one sample per measurement at the reset divider and offset
        sender_idle_pct = 33;
        write_reg(bvg_pkg::CFG_SAMPLE_COUNT, 16'd1);
        foreach (DIRECTED_MV[i])
            queue_sample(DIRECTED_MV[i]);
        drain_block();

        // huge divider ratio with zero bottom resistor and top offset: saturation
        write_reg(bvg_pkg::CFG_DIVIDER_TOP, 16'hFFFF);
        write_reg(bvg_pkg::CFG_DIVIDER_BOTTOM, 16'h0000);
        write_reg(bvg_pkg::CFG_OFFSET, 16'h03FF);
        queue_sample(12'd4095);
        queue_sample(12'd100);
        drain_block();

        // unity-like divider with the most negative offset
        write_reg(bvg_pkg::CFG_DIVIDER_TOP, 16'd1);
        write_reg(bvg_pkg::CFG_DIVIDER_BOTTOM, 16'hFFFF);
        write_reg(bvg_pkg::CFG_OFFSET, 16'hFC00);
        queue_sample(12'd0);
        queue_sample(12'd4095);
        queue_sample(12'd1500);
        drain_block();

        // zero sample count behaves as one
        write_reg(bvg_pkg::CFG_SAMPLE_COUNT, 16'd0);
        queue_sample(12'd2000);
        queue_sample(12'd2001);
        drain_block();

        // count lowered in the middle of a measurement
        write_reg(bvg_pkg::CFG_SAMPLE_COUNT, 16'd4);
        queue_sample(12'd3000);
        queue_sample(12'd3001);
        drain_block();
        write_reg(bvg_pkg::CFG_SAMPLE_COUNT, 16'hFF02);
        queue_sample(12'd3002);
        drain_block();

        // longest measurement with the largest sum
        sender_idle_pct = 0;
        write_reg(bvg_pkg::CFG_SAMPLE_COUNT, 16'(LONG_COUNT));
        write_reg(bvg_pkg::CFG_DIVIDER_TOP, 16'd50);
        write_reg(bvg_pkg::CFG_DIVIDER_BOTTOM, 16'd100);
        write_reg(bvg_pkg::CFG_OFFSET, 16'd0);
        for (k = 0; k < LONG_COUNT; k++)
            queue_sample(12'd4095);
        drain_block();

        // random phases, new register settings each time
        for (p = 0; p < RANDOM_PHASES; p++)
        begin
            sender_idle_pct = (p < 4) ? 33 : ((p < 8) ? 70 : 0);

            pick = $urandom_range(99);
            if (pick < 70)
                count_val = 8'($urandom_range(6, 1));
            else if (pick < 90)
                count_val = 8'($urandom_range(40, 7));
            else
                count_val = 8'($urandom_range(255, 0));
            count_hi = 8'($urandom_range(255));

            pick = $urandom_range(99);
            if (pick < 60)
                top_val = 16'($urandom_range(200, 20));
            else if (pick < 80)
                top_val = 16'($urandom_range(65535));
            else
                top_val = $urandom_range(1) ? 16'hFFFF : 16'd1;

            pick = $urandom_range(99);
            if (pick < 60)
                bot_val = 16'($urandom_range(200, 50));
            else if (pick < 80)
                bot_val = 16'($urandom_range(65535));
            else
                bot_val = $urandom_range(1) ? 16'hFFFF : 16'($urandom_range(1));

            if ($urandom_range(1))
                off_val = 11'($urandom_range(2047));
            else
                off_val = 11'($urandom_range(200)) - 11'd100;
            off_hi = 5'($urandom_range(31));

            write_reg(bvg_pkg::CFG_SAMPLE_COUNT, {count_hi, count_val});
            write_reg(bvg_pkg::CFG_DIVIDER_TOP, top_val);
            write_reg(bvg_pkg::CFG_DIVIDER_BOTTOM, bot_val);
            write_reg(bvg_pkg::CFG_OFFSET, {off_hi, off_val});

            // either a slow upward ramp or scattered readings
            ramp = ($urandom_range(99) < 30);
            level = $urandom_range(2500, 1000);
            for (k = 0; k < ITEMS_PER_PHASE; k++)
            begin
                if (ramp)
                begin
                    level = level + $urandom_range(15, 1);
                    if (level > 4095)
                        level = 4095;
                    queue_sample(12'(level));
                end
                else
                begin
                    pick = $urandom_range(99);
                    if (pick < 5)
                        queue_sample($urandom_range(1) ? 12'd4095 : 12'd0);
                    else if (pick < 65)
                        queue_sample(12'($urandom_range(3200, 1200)));
                    else
                        queue_sample(12'($urandom_range(4095)));
                end
            end
            drain_block();
        end

        if (pending_readings.size() != 0)
        begin
            mismatches += pending_readings.size();
            $display("%0d expected readings never appeared", pending_readings.size());
        end
        $display("run covered %0d samples, %0d readings and %0d register writes",
                 samples_accepted, readings_checked, reg_writes);
        $display("sample counts 0 to 255, divider and offset extremes, %0d rising readings",
                 rising_seen);
        if (mismatches == 0)
            $display("battery_voltage_gauge test passed");
        else
            $display("battery_voltage_gauge test failed");
        $finish;
    end

endmodule
